// ===== hdl/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the slotted page manager.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_SLOTS  = 256;
    localparam int SLOT_BYTES = 4;
    localparam int TID_BYTES  = 8;
    localparam int QDEPTH     = 2;

    localparam int SLOT_W  = 8;                       // slot id
    localparam int CNT_W   = 9;                       // slot count, holds MAX_SLOTS
    localparam int OFF_W   = 13;                      // offset / length
    localparam int ADDR_W  = 12;                      // byte memory address
    localparam int TIDX_W  = $clog2(TID_BYTES);

    typedef enum logic [2:0] {
        CMD_STORE_NEW     = 3'd0,
        CMD_STORE_REPLACE = 3'd1,
        CMD_REDIRECT      = 3'd2,
        CMD_REMOVE        = 3'd3,
        CMD_READ_SLOT     = 3'd4,
        CMD_CHECK_FREE    = 3'd5,
        CMD_WRITE_BYTE    = 3'd6,
        CMD_READ_BYTE     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_RDB,
        BS_TID
    } t_bstate;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  slot_id;
        logic [12:0] length;
        logic [11:0] byte_index;
        logic [7:0]  byte_value;
        logic [63:0] tid;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result_slot;
        logic [12:0] result_offset;
        logic [12:0] result_length;
        logic [7:0]  byte_out;
        logic        fits;
        t_status     status;
    } t_out_item;

    // Decoded command as it travels from front to back.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  slot_id;
        logic [12:0] length;
        logic [12:0] need;        // reserved size, max(length, TID_BYTES)
        logic [11:0] byte_index;
        logic [7:0]  byte_value;
        logic [63:0] tid;
    } t_work;

endpackage

// ===== hdl/slotted_page_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slotted_page_manager
// One database page: slot table growing up, record bytes allocated downward.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  -------   ---------  ---------------  -----------------------------------
//  command   in         start / busy     i_cmd    (spm_pkg::t_in_item)
//  result    out        o_done strobe    o_result (spm_pkg::t_out_item)
//
//  A command transaction is taken when start is high and busy is low; busy
//  rises only while the two-entry command queue is full.
//  Execution: each command has a table read, then an execute step; read_byte
//  adds a registered byte memory read, and redirect then writes the eight tuple-id
//  bytes one at a time through the single byte memory write port.
//  Each result is flagged by o_done for one cycle; it cannot be held.
//  Reset (synchronous, i_rst_n low) clears the queue, the sequencer and the slot
//  count and sets data_start to PAGE_BYTES; the memories are not cleared.
//
module slotted_page_manager (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  spm_pkg::t_in_item  i_cmd,
    output logic               o_done,
    output spm_pkg::t_out_item o_result
);
    import spm_pkg::*;

    logic  q_valid;
    logic  q_pop;
    t_work q_work;

    // front: decode and queue
    spm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_cmd),
        .o_valid (q_valid),
        .o_work  (q_work),
        .i_pop   (q_pop)
    );

    // back: page state, slot table and byte memory
    spm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_work   (q_work),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== hdl/spm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_front
// Accepts command transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module spm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spm_pkg::t_in_item i_item,
    output logic              o_valid,
    output spm_pkg::t_work    o_work,
    input  logic              i_pop
);
    import spm_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    t_work             r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [PTR_W:0]    r_count;
    logic              push;
    logic              pop;
    t_work             dec;

    // decode: command type and reserved size
    always_comb begin
        dec.cmd        = t_cmd'(i_item.command);
        dec.slot_id    = i_item.slot_id;
        dec.length     = i_item.length;
        dec.need       = (i_item.length > OFF_W'(TID_BYTES)) ? i_item.length
                                                             : OFF_W'(TID_BYTES);
        dec.byte_index = i_item.byte_index;
        dec.byte_value = i_item.byte_value;
        dec.tid        = i_item.tid;
    end

    assign busy    = (r_count == (PTR_W+1)'(QDEPTH));
    assign push    = start && !busy;
    assign o_valid = (r_count != '0);
    assign pop     = i_pop && o_valid;
    assign o_work  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(QDEPTH))
        else $error("queue overflow");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count lost a pop");

endmodule

// ===== hdl/spm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_back
// Executes queued commands against the slot table and the page byte memory.
// ----------------------------------------------------------------------------
module spm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  spm_pkg::t_work     i_work,
    output logic               o_pop,
    output logic               o_done,
    output spm_pkg::t_out_item o_result
);
    import spm_pkg::*;

    // memories
    logic [2*OFF_W-1:0] r_tbl [MAX_SLOTS];
    logic [7:0]         r_bm  [PAGE_BYTES];

    t_bstate            r_state, n_state;
    t_work              r_work;
    logic [2*OFF_W-1:0] r_entry;
    logic [7:0]         r_bm_rdata;
    logic [OFF_W-1:0]   r_data_start, n_data_start;
    logic [CNT_W-1:0]   r_slot_count, n_slot_count;
    logic [TIDX_W-1:0]  r_tid_idx, n_tid_idx;
    logic               r_done, n_done;
    t_out_item          r_result, n_result;

    logic                 tbl_we;
    logic [SLOT_W-1:0]    tbl_waddr;
    logic [2*OFF_W-1:0]   tbl_wdata;
    logic                 bm_we;
    logic                 bm_re;
    logic [ADDR_W-1:0]    bm_waddr;
    logic [7:0]           bm_wdata;

    logic [OFF_W-1:0]   ent_off, ent_len, ent_res, new_ds;
    logic [OFF_W:0]     used, free, need_slot, baddr, tid_addr;
    logic               fits_new, slot_ok, range_b;

    assign ent_off   = r_entry[2*OFF_W-1:OFF_W];
    assign ent_len   = r_entry[OFF_W-1:0];
    assign ent_res   = (ent_len > OFF_W'(TID_BYTES)) ? ent_len : OFF_W'(TID_BYTES);
    assign used      = (OFF_W+1)'(r_slot_count) * (OFF_W+1)'(SLOT_BYTES);
    assign free      = ({1'b0, r_data_start} > used) ? ({1'b0, r_data_start} - used) : '0;
    assign need_slot = {1'b0, r_work.need} + (OFF_W+1)'(SLOT_BYTES);
    assign fits_new  = (free >= need_slot) && (r_slot_count < CNT_W'(MAX_SLOTS));
    assign slot_ok   = ({1'b0, r_work.slot_id} < r_slot_count);
    assign new_ds    = r_data_start - r_work.need;
    assign baddr     = {1'b0, ent_off} + (OFF_W+1)'(r_work.byte_index);
    assign range_b   = ({1'b0, r_work.byte_index} >= ent_res)
                       || (baddr >= (OFF_W+1)'(PAGE_BYTES));
    assign tid_addr  = {1'b0, ent_off} + (OFF_W+1)'(r_tid_idx);

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        n_result     = r_result;
        n_data_start = r_data_start;
        n_slot_count = r_slot_count;
        n_tid_idx    = r_tid_idx;
        o_pop        = 1'b0;
        tbl_we       = 1'b0;
        tbl_waddr    = r_work.slot_id;
        tbl_wdata    = r_entry;
        bm_we        = 1'b0;
        bm_re        = 1'b0;
        bm_waddr     = baddr[ADDR_W-1:0];
        bm_wdata     = r_work.byte_value;

        case (r_state)
            BS_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                n_state  = BS_IDLE;
                n_done   = 1'b1;
                n_result = '0;
                n_result.status = ST_OK;
                if (r_work.cmd == CMD_STORE_NEW) begin
                    if (!fits_new) begin
                        n_result.status = ST_NO_SPACE;
                    end else begin
                        n_data_start           = new_ds;
                        n_slot_count           = r_slot_count + 1'b1;
                        tbl_we                 = 1'b1;
                        tbl_waddr              = r_slot_count[SLOT_W-1:0];
                        tbl_wdata              = {new_ds, r_work.length};
                        n_result.result_slot   = r_slot_count[SLOT_W-1:0];
                        n_result.result_offset = new_ds;
                        n_result.result_length = r_work.length;
                    end
                end else if (r_work.cmd == CMD_CHECK_FREE) begin
                    n_result.fits = (free >= need_slot);
                end else if (!slot_ok) begin
                    n_result.result_slot = r_work.slot_id;
                    n_result.status      = ST_RANGE;
                end else begin
                    n_result.result_slot   = r_work.slot_id;
                    n_result.result_offset = ent_off;
                    n_result.result_length = ent_len;
                    case (r_work.cmd)
                        CMD_STORE_REPLACE: begin
                            if (free < {1'b0, r_work.need}) begin
                                n_result.status = ST_NO_SPACE;
                            end else begin
                                n_data_start           = new_ds;
                                tbl_we                 = 1'b1;
                                tbl_wdata              = {new_ds, r_work.length};
                                n_result.result_offset = new_ds;
                                n_result.result_length = r_work.length;
                            end
                        end
                        CMD_REDIRECT: begin
                            tbl_we                 = 1'b1;
                            tbl_wdata              = {ent_off, OFF_W'(0)};
                            n_result.result_length = '0;
                            n_tid_idx              = '0;
                            n_state                = BS_TID;
                        end
                        CMD_REMOVE: begin
                            tbl_we                 = 1'b1;
                            tbl_wdata              = '0;
                            n_result.result_offset = '0;
                            n_result.result_length = '0;
                        end
                        CMD_WRITE_BYTE, CMD_READ_BYTE: begin
                            if (range_b) begin
                                n_result.status = ST_RANGE;
                            end else if (r_work.cmd == CMD_WRITE_BYTE) begin
                                bm_we = 1'b1;
                            end else begin
                                bm_re   = 1'b1;
                                n_done  = 1'b0;
                                n_state = BS_RDB;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_RDB: begin
                n_done            = 1'b1;
                n_result.byte_out = r_bm_rdata;
                n_state           = BS_IDLE;
            end
            BS_TID: begin
                bm_waddr  = tid_addr[ADDR_W-1:0];
                bm_wdata  = r_work.tid[{r_tid_idx, 3'b000} +: 8];
                bm_we     = (tid_addr < (OFF_W+1)'(PAGE_BYTES));
                n_tid_idx = r_tid_idx + 1'b1;
                if (r_tid_idx == TIDX_W'(TID_BYTES - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // slot table: one read (on pop), one write
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= r_tbl[i_work.slot_id];
        end
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
    end

    // page byte memory
    always_ff @(posedge i_clk) begin
        if (bm_re) begin
            r_bm_rdata <= r_bm[baddr[ADDR_W-1:0]];
        end
        if (bm_we) begin
            r_bm[bm_waddr] <= bm_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_work;
        end
        r_result  <= n_result;
        r_tid_idx <= n_tid_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_done       <= 1'b0;
            r_data_start <= OFF_W'(PAGE_BYTES);
            r_slot_count <= '0;
        end else begin
            r_state      <= n_state;
            r_done       <= n_done;
            r_data_start <= n_data_start;
            r_slot_count <= n_slot_count;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_space_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_data_start} >= used)
        else $error("records overlap slot table");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_count <= CNT_W'(MAX_SLOTS))
        else $error("slot count past limit");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == BS_EXEC && !o_done))
        else $error("pop did not start execution");

endmodule
